>>> hdl/dtr_pkg.sv
// Shared types, register indexes and reset values for the debounced toggle relay timer.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package dtr_pkg;

    localparam int CHANNELS_DEFAULT = 4;

    localparam int DEB_W   = 10;
    localparam int REL_W   = 20;
    localparam int BUZ_W   = 16;
    localparam int BLK_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    typedef logic [DEB_W-1:0]     deb_cnt_t;
    typedef logic [REL_W-1:0]     rel_cnt_t;
    typedef logic [BUZ_W-1:0]     buz_cnt_t;
    typedef logic [BLK_W-1:0]     blk_cnt_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_DEBOUNCE = 2'd0;
    localparam cfg_idx_t REG_TIMEOUT  = 2'd1;
    localparam cfg_idx_t REG_BUZZER   = 2'd2;
    localparam cfg_idx_t REG_BLINK    = 2'd3;

    localparam deb_cnt_t DEBOUNCE_RESET = 10'd30;
    localparam rel_cnt_t TIMEOUT_RESET  = 20'd60000;
    localparam buz_cnt_t BUZZER_RESET   = 16'd3000;
    localparam blk_cnt_t BLINK_RESET    = 16'd500;

    function automatic deb_cnt_t sat_inc_deb(input deb_cnt_t v);
        return (v == '1) ? v : v + deb_cnt_t'(1);
    endfunction

    function automatic rel_cnt_t sat_inc_rel(input rel_cnt_t v);
        return (v == '1) ? v : v + rel_cnt_t'(1);
    endfunction

    function automatic buz_cnt_t sat_inc_buz(input buz_cnt_t v);
        return (v == '1) ? v : v + buz_cnt_t'(1);
    endfunction

    function automatic blk_cnt_t sat_inc_blk(input blk_cnt_t v);
        return (v == '1) ? v : v + blk_cnt_t'(1);
    endfunction

endpackage

>>> hdl/debounced_toggle_relay_timer_top.sv
// A tick item is taken into the input register, and its result is written to the result
// register together with the state update; a stalled result side holds both registers.
// One item per cycle while the result side is not stalled; the only loop is the per-tick
// state update, which closes between the input register and the result register.
// Reset (rst_n low, asynchronous): levels high, counters zero, relays and buzzer off,
// LED on, registers at their defaults; no clearing pass is needed. Depends on dtr_pkg.
`timescale 1ns / 1ps

module debounced_toggle_relay_timer_top
    import dtr_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CHANNELS-1:0]   button_levels,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CHANNELS-1:0]   relay_outputs,
    output logic                  buzzer_on,
    output logic                  status_led,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    deb_cnt_t deb_ticks_reg;
    rel_cnt_t timeout_ticks_reg;
    buz_cnt_t buzzer_ticks_reg;
    blk_cnt_t blink_ticks_reg;

    // input register
    logic                s1_valid_reg;
    logic [CHANNELS-1:0] s1_levels_reg;
    logic                advance;

    // block state
    logic [CHANNELS-1:0] last_reg,   last_next;
    logic [CHANNELS-1:0] stable_reg, stable_next;
    logic [CHANNELS-1:0] relay_reg,  relay_next;
    deb_cnt_t            deb_reg  [CHANNELS];
    deb_cnt_t            deb_next [CHANNELS];
    rel_cnt_t            rel_reg  [CHANNELS];
    rel_cnt_t            rel_next [CHANNELS];
    logic                buzz_reg,     buzz_next;
    buz_cnt_t            buz_cnt_reg,  buz_cnt_next;
    blk_cnt_t            blk_cnt_reg,  blk_cnt_next;
    logic                led_reg,      led_next;
    logic                buzz_req;

    // result register
    logic                out_valid_reg;
    logic [CHANNELS-1:0] out_relay_reg;
    logic                out_buzz_reg;
    logic                out_led_reg;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_ticks_reg     <= DEBOUNCE_RESET;
            timeout_ticks_reg <= TIMEOUT_RESET;
            buzzer_ticks_reg  <= BUZZER_RESET;
            blink_ticks_reg   <= BLINK_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE: deb_ticks_reg     <= cfg_data[DEB_W-1:0];
                REG_TIMEOUT:  timeout_ticks_reg <= cfg_data[REL_W-1:0];
                REG_BUZZER:   buzzer_ticks_reg  <= cfg_data[BUZ_W-1:0];
                REG_BLINK:    blink_ticks_reg   <= cfg_data[BLK_W-1:0];
                default:      ;
            endcase
        end
    end

    // hold the item while the result register is full and stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_levels_reg <= button_levels;
    end

    // per-tick update: counters advance first, then each channel, heartbeat, buzzer
    always_comb
    begin
        last_next   = s1_levels_reg;
        stable_next = stable_reg;
        relay_next  = relay_reg;
        buzz_req    = 1'b0;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            deb_next[ch] = (s1_levels_reg[ch] != last_reg[ch]) ? '0 : sat_inc_deb(deb_reg[ch]);
            rel_next[ch] = sat_inc_rel(rel_reg[ch]);
            if (deb_next[ch] >= deb_ticks_reg && s1_levels_reg[ch] != stable_reg[ch])
            begin
                stable_next[ch] = s1_levels_reg[ch];
                if (!s1_levels_reg[ch])
                begin
                    relay_next[ch] = !relay_reg[ch];
                    if (relay_next[ch])
                    begin
                        rel_next[ch] = '0;
                        buzz_req     = 1'b1;
                    end
                end
            end
            if (relay_next[ch] && rel_next[ch] >= timeout_ticks_reg)
                relay_next[ch] = 1'b0;
        end

        blk_cnt_next = sat_inc_blk(blk_cnt_reg);
        led_next     = led_reg;
        if (blk_cnt_next >= blink_ticks_reg)
        begin
            led_next     = !led_reg;
            blk_cnt_next = '0;
        end

        buz_cnt_next = sat_inc_buz(buz_cnt_reg);
        buzz_next    = buzz_reg;
        if (buzz_req)
        begin
            buzz_next    = 1'b1;
            buz_cnt_next = '0;
        end
        if (buzz_next && buz_cnt_next >= buzzer_ticks_reg)
            buzz_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg    <= '1;
            stable_reg  <= '1;
            relay_reg   <= '0;
            buzz_reg    <= 1'b0;
            buz_cnt_reg <= '0;
            blk_cnt_reg <= '0;
            led_reg     <= 1'b1;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                deb_reg[ch] <= '0;
                rel_reg[ch] <= '0;
            end
        end
        else if (s1_valid_reg && advance)
        begin
            last_reg    <= last_next;
            stable_reg  <= stable_next;
            relay_reg   <= relay_next;
            buzz_reg    <= buzz_next;
            buz_cnt_reg <= buz_cnt_next;
            blk_cnt_reg <= blk_cnt_next;
            led_reg     <= led_next;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                deb_reg[ch] <= deb_next[ch];
                rel_reg[ch] <= rel_next[ch];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && advance)
        begin
            out_relay_reg <= relay_next;
            out_buzz_reg  <= buzz_next;
            out_led_reg   <= led_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign relay_outputs = out_relay_reg;
    assign buzzer_on     = out_buzz_reg;
    assign status_led    = out_led_reg;

endmodule

>>> hdl/dtr_checker.sv
// Port-level checker for the debounced toggle relay timer, bound to the top level.
// Depends on dtr_pkg and debounced_toggle_relay_timer_top.
`timescale 1ns / 1ps

module dtr_checker
    import dtr_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [CHANNELS-1:0] relay_outputs,
    input logic                buzzer_on,
    input logic                status_led
);

    // input side only backs up when the result is held
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while result side is free");

    // an item taken while no result is held passes the input and result registers to the output
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |-> ##2 out_valid)
        else $error("accepted item did not reach the output");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(relay_outputs)
            && $stable(buzzer_on) && $stable(status_led))
        else $error("stalled result changed");

endmodule

bind debounced_toggle_relay_timer_top dtr_checker #(
    .CHANNELS (CHANNELS)
) u_dtr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .relay_outputs (relay_outputs),
    .buzzer_on     (buzzer_on),
    .status_led    (status_led)
);

>>> tb/debounced_toggle_relay_timer_top_tb.sv
// Self-checking testbench for debounced_toggle_relay_timer_top: tick items, relay/buzzer/LED results.
// Holds its own model of the relay panel and compares every result item in order.
// Depends on dtr_pkg and the top level.
`timescale 1ns / 1ps

module debounced_toggle_relay_timer_top_tb;
    import dtr_pkg::*;

    localparam int NCH = 4;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic [NCH-1:0] lvl_t;

    typedef struct packed {
        lvl_t relays;
        logic buzzer;
        logic led;
    } panel_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    lvl_t                  button_levels = '1;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    lvl_t                  relay_outputs;
    logic                  buzzer_on;
    logic                  status_led;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    lvl_t   button_ticks [$];
    panel_t pending_panels [$];
    bit     item_taken = 1'b0;
    bit     calm = 1'b0;
    int     cycles = 0;
    int     errors = 0;

    // panel model: registers and state
    deb_cnt_t deb_limit;
    rel_cnt_t relay_limit;
    buz_cnt_t buzz_limit;
    blk_cnt_t blink_limit;
    lvl_t     prev_levels;
    lvl_t     settled;
    lvl_t     relay_state;
    deb_cnt_t deb_age [NCH];
    rel_cnt_t relay_age [NCH];
    logic     buzz_active;
    buz_cnt_t buzz_age;
    blk_cnt_t blink_age;
    logic     led;

    debounced_toggle_relay_timer_top #(.CHANNELS(NCH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .button_levels (button_levels),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .relay_outputs (relay_outputs),
        .buzzer_on     (buzzer_on),
        .status_led    (status_led),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic panel_t panel_after_tick(input lvl_t levels);
        logic   buzz_req;
        panel_t r;
        buzz_req = 1'b0;
        // advance all counters first, saturating at full scale
        for (int ch = 0; ch < NCH; ch++) begin
            if (deb_age[ch] != '1) deb_age[ch] = deb_age[ch] + 1'b1;
            if (relay_age[ch] != '1) relay_age[ch] = relay_age[ch] + 1'b1;
        end
        if (buzz_age != '1) buzz_age = buzz_age + 1'b1;
        if (blink_age != '1) blink_age = blink_age + 1'b1;

        for (int ch = 0; ch < NCH; ch++) begin
            if (levels[ch] != prev_levels[ch]) deb_age[ch] = '0;
            if (deb_age[ch] >= deb_limit && levels[ch] != settled[ch]) begin
                settled[ch] = levels[ch];
                // a settled press toggles; turning on restarts the auto-off timer
                if (!levels[ch]) begin
                    relay_state[ch] = ~relay_state[ch];
                    if (relay_state[ch]) begin
                        relay_age[ch] = '0;
                        buzz_req = 1'b1;
                    end
                end
            end
            if (relay_state[ch] && relay_age[ch] >= relay_limit) relay_state[ch] = 1'b0;
            prev_levels[ch] = levels[ch];
        end

        if (blink_age >= blink_limit) begin
            led = ~led;
            blink_age = '0;
        end
        if (buzz_req) begin
            buzz_active = 1'b1;
            buzz_age = '0;
        end
        if (buzz_active && buzz_age >= buzz_limit) buzz_active = 1'b0;

        r.relays = relay_state;
        r.buzzer = buzz_active;
        r.led = led;
        return r;
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        // the block keeps only the register's low bits
        case (idx)
            REG_DEBOUNCE: deb_limit = deb_cnt_t'(value);
            REG_TIMEOUT:  relay_limit = rel_cnt_t'(value);
            REG_BUZZER:   buzz_limit = buz_cnt_t'(value);
            REG_BLINK:    blink_limit = blk_cnt_t'(value);
            default:      ;
        endcase
    endtask

    task automatic push_ticks(input lvl_t levels, input int count);
        repeat (count) button_ticks.push_back(levels);
    endtask

    // press/release sequences: bounce, then a hold that mostly outlasts the debounce
    task automatic queue_random_ticks(input int budget, input int settle);
        int   made;
        int   hold;
        lvl_t target;
        lvl_t lv;
        made = 0;
        while (made < budget) begin
            target = lvl_t'($urandom);
            if ($urandom_range(99) < 15) begin
                hold = $urandom_range(1, 4);
                repeat (hold) button_ticks.push_back(lvl_t'($urandom));
                made += hold;
            end
            else begin
                hold = $urandom_range(0, 3);
                repeat (hold) button_ticks.push_back(lvl_t'($urandom));
                made += hold;
                hold = ($urandom_range(99) < 80) ? settle + $urandom_range(1, 6)
                                                 : $urandom_range(0, settle);
                repeat (hold) begin
                    lv = target;
                    if ($urandom_range(99) < 4) lv[$urandom_range(NCH - 1)] = ~lv[$urandom_range(NCH - 1)];
                    button_ticks.push_back(lv);
                end
                made += hold;
            end
        end
    endtask

    // wait for every item to be taken and every result to arrive, then let the pipe settle
    task automatic drain_panels();
        while (button_ticks.size() != 0 || in_valid) @(negedge clk);
        while (pending_panels.size() != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // driver
    always @(negedge clk) begin
        logic go;
        if (rst_n && (!in_valid || item_taken)) begin
            go = button_ticks.size() != 0 && (calm || $urandom_range(99) >= 26);
            if (go) begin
                in_valid <= 1'b1;
                button_levels <= button_ticks.pop_front();
            end
            else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= rst_n && !calm && ($urandom_range(99) < 26);
    end

    // monitor: predict on input accept, check on output accept
    always @(posedge clk) begin
        panel_t want;
        if (rst_n) begin
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
            else begin
                if (out_valid && !out_stall) begin
                    if (pending_panels.size() == 0) begin
                        $error("result item with nothing pending: relays %0h", relay_outputs);
                        errors++;
                    end
                    else begin
                        want = pending_panels.pop_front();
                        if (relay_outputs !== want.relays) begin
                            $error("relay_outputs: expected %0h, got %0h", want.relays, relay_outputs);
                            errors++;
                        end
                        if (buzzer_on !== want.buzzer) begin
                            $error("buzzer_on: expected %0b, got %0b", want.buzzer, buzzer_on);
                            errors++;
                        end
                        if (status_led !== want.led) begin
                            $error("status_led: expected %0b, got %0b", want.led, status_led);
                            errors++;
                        end
                    end
                end
                item_taken = in_valid && !in_stall;
                if (item_taken) pending_panels.push_back(panel_after_tick(button_levels));
            end
        end
    end

    initial begin
        deb_limit = DEBOUNCE_RESET;
        relay_limit = TIMEOUT_RESET;
        buzz_limit = BUZZER_RESET;
        blink_limit = BLINK_RESET;
        prev_levels = '1;
        settled = '1;
        relay_state = '0;
        for (int ch = 0; ch < NCH; ch++) begin
            deb_age[ch] = '0;
            relay_age[ch] = '0;
        end
        buzz_active = 1'b0;
        buzz_age = '0;
        blink_age = '0;
        led = 1'b1;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // reset values of all registers
        queue_random_ticks(60, 30);
        drain_panels();

        // short debounce, quick timeout, LED toggling every tick
        write_reg(REG_DEBOUNCE, 20'd1);
        write_reg(REG_TIMEOUT, 20'd4);
        write_reg(REG_BUZZER, 20'd2);
        write_reg(REG_BLINK, 20'd0);
        push_ticks(4'hF, 2);
        push_ticks(4'hE, 3);
        push_ticks(4'hF, 2);
        push_ticks(4'h0, 3);
        push_ticks(4'hF, 2);
        push_ticks(4'h0, 2);
        push_ticks(4'hF, 1);
        push_ticks(4'h5, 1);
        push_ticks(4'hA, 1);
        push_ticks(4'h5, 1);
        push_ticks(4'h7, 2);
        push_ticks(4'hB, 2);
        push_ticks(4'hD, 1);
        push_ticks(4'hF, 2);
        drain_panels();

        // zero delays: accept at once, relay and buzzer end in the tick they start
        write_reg(REG_DEBOUNCE, 20'd0);
        write_reg(REG_TIMEOUT, 20'd0);
        write_reg(REG_BUZZER, 20'd0);
        write_reg(REG_BLINK, 20'd1);
        queue_random_ticks(50, 0);
        drain_panels();

        // long stretch without any idling on either side
        write_reg(REG_DEBOUNCE, 20'd3);
        write_reg(REG_TIMEOUT, 20'd20);
        write_reg(REG_BUZZER, 20'd5);
        write_reg(REG_BLINK, 20'd7);
        @(posedge clk) calm = 1'b1;
        queue_random_ticks(100, 3);
        drain_panels();
        @(posedge clk) calm = 1'b0;

        // oversized writes keep only the low bits; longest timeout
        write_reg(REG_DEBOUNCE, {10'h2A5, 10'd4});
        write_reg(REG_TIMEOUT, 20'hFFFFF);
        write_reg(REG_BUZZER, {4'hF, 16'd6});
        write_reg(REG_BLINK, {4'hA, 16'd3});
        queue_random_ticks(80, 4);
        drain_panels();

        // long debounce: a short press is dropped, a long hold is taken at the limit
        write_reg(REG_DEBOUNCE, 20'd200);
        write_reg(REG_TIMEOUT, 20'd1);
        write_reg(REG_BUZZER, 20'hFFFF);
        write_reg(REG_BLINK, 20'hFFFF);
        push_ticks(4'hF, 3);
        push_ticks(4'h0, 1);
        push_ticks(4'hF, 1);
        push_ticks(4'h0, 205);
        push_ticks(4'hF, 5);
        drain_panels();

        write_reg(REG_DEBOUNCE, 20'($urandom_range(1, 8)));
        write_reg(REG_TIMEOUT, 20'($urandom_range(1, 60)));
        write_reg(REG_BUZZER, 20'($urandom_range(1, 30)));
        write_reg(REG_BLINK, 20'($urandom_range(1, 15)));
        queue_random_ticks(80, int'(deb_limit));
        drain_panels();

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
